[design/mau_pkg.sv]
// shared types and constants for the monomial arithmetic unit
package mau_pkg;

    localparam int MAU_NUM_VARS  = 8;
    localparam int MAU_EXP_BITS  = 8;
    localparam int MAU_COEF_BITS = 32;

    localparam int MAU_COEF_W = 32;
    localparam int MAU_EXPS_W = 64;
    localparam int MAU_OP_W   = 2;
    localparam int MAU_CFG_W  = 4;

    localparam logic [MAU_CFG_W-1:0] MAU_ACTIVE_RESET = 4'd8;

    typedef enum logic [MAU_OP_W-1:0] {
        OP_GCD  = 2'd0,
        OP_MUL  = 2'd1,
        OP_ADD  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_COEF_OVF = 2'd2,
        ST_EXP_OVF  = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic gcd_start;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_gcd;
        logic gcd_done;
    } t_dp_stat;

endpackage

[design/monomial_arithmetic_unit.sv]
// top level of the monomial arithmetic unit
//
//   channel  direction  handshake                 payload
//   input    in         i_in_valid / o_in_stall   i_operation i_coef_a i_exps_a i_coef_b i_exps_b
//   output   out        o_out_valid / i_out_stall o_res_coef o_res_exps o_status
//   config   in         i_cfg_we                  i_cfg_wdata (active_vars)
//
// multiply, add and unused op: S_IDLE (load), S_EXEC, then S_FINISH (result word)
// gcd: S_GCD waits for the binary gcd loop, one step per cycle
// one word in flight; the next word is taken while the result waits in the output register
// a finished result waits for the output register to free up when the output stalls
// reset is synchronous, active low; active_vars resets to 8
module monomial_arithmetic_unit import mau_pkg::*; #(
    parameter int NUM_VARS  = MAU_NUM_VARS,
    parameter int EXP_BITS  = MAU_EXP_BITS,
    parameter int COEF_BITS = MAU_COEF_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [MAU_OP_W-1:0]   i_operation,
    input  logic [MAU_COEF_W-1:0] i_coef_a,
    input  logic [MAU_EXPS_W-1:0] i_exps_a,
    input  logic [MAU_COEF_W-1:0] i_coef_b,
    input  logic [MAU_EXPS_W-1:0] i_exps_b,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [MAU_COEF_W-1:0] o_res_coef,
    output logic [MAU_EXPS_W-1:0] o_res_exps,
    output logic [1:0]            o_status,
    input  logic                  i_cfg_we,
    input  logic [MAU_CFG_W-1:0]  i_cfg_wdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    mau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    mau_dp #(
        .NUM_VARS  (NUM_VARS),
        .EXP_BITS  (EXP_BITS),
        .COEF_BITS (COEF_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_operation (i_operation),
        .i_coef_a    (i_coef_a),
        .i_exps_a    (i_exps_a),
        .i_coef_b    (i_coef_b),
        .i_exps_b    (i_exps_b),
        .o_res_coef  (o_res_coef),
        .o_res_exps  (o_res_exps),
        .o_status    (o_status)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a word is in progress");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word without a word in progress");

    a_exp_ovf_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EXP_OVF)) |-> (o_res_exps != '0))
        else $error("exponent overflow with all exponents zero");
`endif

endmodule

[design/mau_gcd.sv]
// iterative binary gcd of two unsigned magnitudes, one step per cycle
module mau_gcd import mau_pkg::*; #(
    parameter int MAG_BITS = MAU_COEF_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MAG_BITS-1:0] i_a,
    input  logic [MAG_BITS-1:0] i_b,
    output logic                o_done,
    output logic [MAG_BITS-1:0] o_gcd
);

    localparam int KW = $clog2(MAG_BITS);

    logic                r_busy;
    logic                r_done;
    logic [MAG_BITS-1:0] r_a;
    logic [MAG_BITS-1:0] r_b;
    logic [MAG_BITS-1:0] r_g;
    logic [KW-1:0]       r_k;
    logic                w_fin;

    assign w_fin = (r_a == '0) || (r_b == '0) || (r_a == r_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_fin) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_k <= '0;
        end else if (r_busy) begin
            if (w_fin) begin
                r_g <= ((r_a == '0) ? r_b : r_a) << r_k;
            end else if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a > r_b) begin
                r_a <= (r_a - r_b) >> 1;
            end else begin
                r_b <= (r_b - r_a) >> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_g;

endmodule

[design/mau_dp.sv]
// datapath: operand and config registers, product, exponent lanes, result register
module mau_dp import mau_pkg::*; #(
    parameter int NUM_VARS  = MAU_NUM_VARS,
    parameter int EXP_BITS  = MAU_EXP_BITS,
    parameter int COEF_BITS = MAU_COEF_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_we,
    input  logic [MAU_CFG_W-1:0]  i_cfg_wdata,
    input  logic [MAU_OP_W-1:0]   i_operation,
    input  logic [MAU_COEF_W-1:0] i_coef_a,
    input  logic [MAU_EXPS_W-1:0] i_exps_a,
    input  logic [MAU_COEF_W-1:0] i_coef_b,
    input  logic [MAU_EXPS_W-1:0] i_exps_b,
    output logic [MAU_COEF_W-1:0] o_res_coef,
    output logic [MAU_EXPS_W-1:0] o_res_exps,
    output logic [1:0]            o_status
);

    localparam int     EW   = NUM_VARS * EXP_BITS;
    localparam longint CMAX = (longint'(1) <<< (COEF_BITS - 1)) - longint'(1);
    localparam logic [EXP_BITS-1:0] EMAX = '1;

    logic [MAU_CFG_W-1:0]         r_av;
    t_op                          r_op;
    logic signed [COEF_BITS-1:0]  r_ca;
    logic signed [COEF_BITS-1:0]  r_cb;
    logic [EW-1:0]                r_ea;
    logic [EW-1:0]                r_eb;
    logic signed [2*COEF_BITS-1:0] r_prod;
    logic [MAU_COEF_W-1:0]        r_res_coef;
    logic [MAU_EXPS_W-1:0]        r_res_exps;
    t_status                      r_status;

    logic [COEF_BITS-1:0]         w_mag_a;
    logic [COEF_BITS-1:0]         w_mag_b;
    logic                         w_gcd_done;
    logic [COEF_BITS-1:0]         w_gcd;
    logic signed [COEF_BITS:0]    w_sum;
    logic [EW-1:0]                w_ex_min;
    logic [EW-1:0]                w_ex_sum;
    logic [EW-1:0]                w_ex_a;
    logic                         w_mismatch;
    logic                         w_eovf;
    logic signed [COEF_BITS-1:0]  w_rc;
    logic [EW-1:0]                w_re;
    logic                         w_covf;
    t_status                      w_st;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= MAU_ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_av <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_op'(i_operation);
            r_ca <= i_coef_a[COEF_BITS-1:0];
            r_cb <= i_coef_b[COEF_BITS-1:0];
            r_ea <= i_exps_a[EW-1:0];
            r_eb <= i_exps_b[EW-1:0];
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_ca * r_cb;
        end
        if (i_cmd.finish) begin
            r_res_coef <= MAU_COEF_W'(w_rc);
            r_res_exps <= MAU_EXPS_W'(w_re);
            r_status   <= w_st;
        end
    end

    assign w_mag_a = r_ca[COEF_BITS-1] ? (~unsigned'(r_ca) + 1'b1) : unsigned'(r_ca);
    assign w_mag_b = r_cb[COEF_BITS-1] ? (~unsigned'(r_cb) + 1'b1) : unsigned'(r_cb);

    mau_gcd #(
        .MAG_BITS (COEF_BITS)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.gcd_start),
        .i_a     (w_mag_a),
        .i_b     (w_mag_b),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    // per-variable exponent lanes
    always_comb begin
        logic [EXP_BITS-1:0] x;
        logic [EXP_BITS-1:0] y;
        logic [EXP_BITS:0]   s;
        w_ex_min   = '0;
        w_ex_sum   = '0;
        w_ex_a     = '0;
        w_mismatch = 1'b0;
        w_eovf     = 1'b0;
        for (int i = 0; i < NUM_VARS; i++) begin
            x = r_ea[i*EXP_BITS +: EXP_BITS];
            y = r_eb[i*EXP_BITS +: EXP_BITS];
            s = {1'b0, x} + {1'b0, y};
            if (r_av > MAU_CFG_W'(i)) begin
                w_ex_min[i*EXP_BITS +: EXP_BITS] = (x < y) ? x : y;
                w_ex_sum[i*EXP_BITS +: EXP_BITS] = s[EXP_BITS] ? EMAX : s[EXP_BITS-1:0];
                w_ex_a[i*EXP_BITS +: EXP_BITS]   = x;
                if (s[EXP_BITS]) begin
                    w_eovf = 1'b1;
                end
                if (x != y) begin
                    w_mismatch = 1'b1;
                end
            end
        end
    end

    assign w_sum = r_ca + r_cb;

    always_comb begin
        w_rc   = '0;
        w_re   = '0;
        w_covf = 1'b0;
        w_st   = ST_OK;
        case (r_op)
            OP_GCD: begin
                if (longint'(w_gcd) > CMAX) begin
                    w_rc   = COEF_BITS'(CMAX);
                    w_covf = 1'b1;
                end else begin
                    w_rc = signed'(w_gcd);
                end
                w_re = w_ex_min;
                w_st = w_covf ? ST_COEF_OVF : ST_OK;
            end
            OP_MUL: begin
                if (r_prod > CMAX) begin
                    w_rc   = COEF_BITS'(CMAX);
                    w_covf = 1'b1;
                end else if (r_prod < -CMAX) begin
                    w_rc   = COEF_BITS'(-CMAX);
                    w_covf = 1'b1;
                end else begin
                    w_rc = r_prod[COEF_BITS-1:0];
                end
                w_re = w_ex_sum;
                w_st = w_covf ? ST_COEF_OVF : (w_eovf ? ST_EXP_OVF : ST_OK);
            end
            OP_ADD: begin
                if (w_mismatch) begin
                    // most negative input folds to the symmetric range, no flag
                    w_rc = (r_ca < -CMAX) ? COEF_BITS'(-CMAX) : r_ca;
                end else if (w_sum > CMAX) begin
                    w_rc   = COEF_BITS'(CMAX);
                    w_covf = 1'b1;
                end else if (w_sum < -CMAX) begin
                    w_rc   = COEF_BITS'(-CMAX);
                    w_covf = 1'b1;
                end else begin
                    w_rc = w_sum[COEF_BITS-1:0];
                end
                w_re = w_ex_a;
                w_st = w_mismatch ? ST_MISMATCH : (w_covf ? ST_COEF_OVF : ST_OK);
            end
            default: begin
                w_rc   = '0;
                w_re   = '0;
                w_covf = 1'b0;
                w_st   = ST_OK;
            end
        endcase
    end

    assign o_stat.is_gcd   = (r_op == OP_GCD);
    assign o_stat.gcd_done = w_gcd_done;
    assign o_res_coef      = r_res_coef;
    assign o_res_exps      = r_res_exps;
    assign o_status        = r_status;

endmodule

[design/mau_ctrl.sv]
// controller state machine: input and output handshakes and datapath sequencing
module mau_ctrl import mau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GCD,
        S_FINISH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_in_stall;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state     = r_state;
        w_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                w_cmd.mul_en = 1'b1;
                if (i_stat.is_gcd) begin
                    w_cmd.gcd_start = 1'b1;
                    n_state         = S_GCD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_GCD: begin
                if (i_stat.gcd_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait until the output word has been taken
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= (n_state != S_IDLE);
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule
